/* sv/tic_pkg.sv */
package tic_pkg;

   localparam int TIC_COORD_BITS = 16;
   localparam int TIC_FRAC_BITS  = 12;
   localparam int TIC_NUM_VERTS  = 3;
   localparam int TIC_NUM_CAND   = 2 * TIC_NUM_VERTS;

   typedef logic [1:0] count_type;

endpackage

/* sv/triangle_isoline_crossings.sv */
// triangle_isoline_crossings
// Finds where the zero isoline of a sampled field crosses one triangle.
// Input channel (req_): three vertices, each with x, y and the field value,
// signed fixed point. Result channel (rsp_): crossing count and three point
// slots in the order found, unused slots zero. Both channels use valid and
// ready; a word moves at a clock edge where both are high.
// Throughput: one triangle per cycle while the receiver does not stall. The
// pipeline is the input and setup registers, then the restoring divider
// that produces one ratio bit per pipeline stage, then the multiply, round
// and output registers.
// When the receiver stalls, the word in the output register moves into a
// skid register and the pipeline advances once more; it then holds, and
// req_ready stays low until the skid word is taken. No word is lost or
// repeated. Synchronous reset clears all valid bits, the skid valid bit
// among them; req_ready is high in the cycle after reset.
module triangle_isoline_crossings #(
   parameter int COORD_BITS = tic_pkg::TIC_COORD_BITS,
   parameter int FRAC_BITS  = tic_pkg::TIC_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_a_value,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_b_value,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_c_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tic_pkg::count_type           rsp_crossing_count,
   output logic signed [COORD_BITS-1:0] rsp_point0_x,
   output logic signed [COORD_BITS-1:0] rsp_point0_y,
   output logic signed [COORD_BITS-1:0] rsp_point1_x,
   output logic signed [COORD_BITS-1:0] rsp_point1_y,
   output logic signed [COORD_BITS-1:0] rsp_point2_x,
   output logic signed [COORD_BITS-1:0] rsp_point2_y
);
   import tic_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int W1 = CB + 1;
   localparam int DL = F + 2;
   localparam int NS = F + 5;
   localparam int NV = TIC_NUM_VERTS;
   localparam int NC = TIC_NUM_CAND;

   logic en;

   logic [NS-1:0] vld_ff;
   logic          skid_vld_ff;

   logic signed [CB-1:0] px_in [NV];
   logic signed [CB-1:0] py_in [NV];
   logic signed [CB-1:0] pv_in [NV];
   logic signed [CB-1:0] px_ff [NV];
   logic signed [CB-1:0] py_ff [NV];
   logic signed [CB-1:0] pv_ff [NV];

   logic [NV-1:0]        zf1_in;
   logic [NV-1:0]        ef1_in;
   logic signed [CB-1:0] bx1_in  [NV];
   logic signed [CB-1:0] by1_in  [NV];
   logic signed [CB:0]   dx1_in  [NV];
   logic signed [CB:0]   dy1_in  [NV];
   logic [CB-1:0]        num1_in [NV];
   logic [CB-1:0]        den1_in [NV];
   logic [NV-1:0]        zf1_ff;
   logic [NV-1:0]        ef1_ff;
   logic signed [CB-1:0] bx1_ff  [NV];
   logic signed [CB-1:0] by1_ff  [NV];
   logic signed [CB:0]   dx1_ff  [NV];
   logic signed [CB:0]   dy1_ff  [NV];
   logic [CB-1:0]        num1_ff [NV];
   logic [CB-1:0]        den1_ff [NV];

   logic [NV-1:0]        zf_ff [DL];
   logic [NV-1:0]        ef_ff [DL];
   logic signed [CB-1:0] bx_ff [DL][NV];
   logic signed [CB-1:0] by_ff [DL][NV];
   logic signed [CB:0]   dx_ff [F][NV];
   logic signed [CB:0]   dy_ff [F][NV];

   logic [F-1:0]         quo [NV];
   logic signed [CB-1:0] lx  [NV];
   logic signed [CB-1:0] ly  [NV];

   count_type            cnt_in;
   logic signed [CB-1:0] ox_in [NV];
   logic signed [CB-1:0] oy_in [NV];
   count_type            cnt_ff;
   logic signed [CB-1:0] ox_ff [NV];
   logic signed [CB-1:0] oy_ff [NV];

   count_type            skc_ff;
   logic signed [CB-1:0] skx_ff [NV];
   logic signed [CB-1:0] sky_ff [NV];

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   // input register
   assign px_in[0] = req_vertex_a_x;
   assign py_in[0] = req_vertex_a_y;
   assign pv_in[0] = req_vertex_a_value;
   assign px_in[1] = req_vertex_b_x;
   assign py_in[1] = req_vertex_b_y;
   assign pv_in[1] = req_vertex_b_value;
   assign px_in[2] = req_vertex_c_x;
   assign py_in[2] = req_vertex_c_y;
   assign pv_in[2] = req_vertex_c_value;

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pv_ff <= pv_in;
      end
   end

   // edge setup: zero vertices, sign changes, divider operands
   always_comb begin
      logic signed [CB:0] vi;
      logic signed [CB:0] vj;
      logic signed [CB:0] d;
      logic signed [CB:0] an;
      logic signed [CB:0] ad;
      int j;
      for (int i = 0; i < NV; i++) begin
         j          = (i == NV - 1) ? 0 : i + 1;
         vi         = W1'(pv_ff[i]);
         vj         = W1'(pv_ff[j]);
         d          = vi - vj;
         an         = (vi < 0) ? -vi : vi;
         ad         = (d < 0) ? -d : d;
         zf1_in[i]  = (vi == 0);
         ef1_in[i]  = (vi < 0 && vj > 0) || (vi > 0 && vj < 0);
         num1_in[i] = an[CB-1:0];
         den1_in[i] = ad[CB-1:0];
         bx1_in[i]  = px_ff[i];
         by1_in[i]  = py_ff[i];
         dx1_in[i]  = W1'(px_ff[j]) - W1'(px_ff[i]);
         dy1_in[i]  = W1'(py_ff[j]) - W1'(py_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zf1_ff  <= zf1_in;
         ef1_ff  <= ef1_in;
         bx1_ff  <= bx1_in;
         by1_ff  <= by1_in;
         dx1_ff  <= dx1_in;
         dy1_ff  <= dy1_in;
         num1_ff <= num1_in;
         den1_ff <= den1_in;
      end
   end

   // side payload, aligned with divider and interpolation stages
   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff[0] <= zf1_ff;
         ef_ff[0] <= ef1_ff;
         bx_ff[0] <= bx1_ff;
         by_ff[0] <= by1_ff;
         dx_ff[0] <= dx1_ff;
         dy_ff[0] <= dy1_ff;
         for (int k = 1; k < DL; k++) begin
            zf_ff[k] <= zf_ff[k-1];
            ef_ff[k] <= ef_ff[k-1];
            bx_ff[k] <= bx_ff[k-1];
            by_ff[k] <= by_ff[k-1];
         end
         for (int k = 1; k < F; k++) begin
            dx_ff[k] <= dx_ff[k-1];
            dy_ff[k] <= dy_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < NV; i++) begin : g_edge
      tic_divider #(
         .COORD_BITS (CB),
         .FRAC_BITS  (F)
      ) u_div (
         .clock (clock),
         .en    (en),
         .num   (num1_ff[i]),
         .den   (den1_ff[i]),
         .quo   (quo[i])
      );

      tic_lerp #(
         .COORD_BITS (CB),
         .FRAC_BITS  (F)
      ) u_lerp_x (
         .clock  (clock),
         .en     (en),
         .base   (bx_ff[F-1][i]),
         .diff   (dx_ff[F-1][i]),
         .ratio  (quo[i]),
         .result (lx[i])
      );

      tic_lerp #(
         .COORD_BITS (CB),
         .FRAC_BITS  (F)
      ) u_lerp_y (
         .clock  (clock),
         .en     (en),
         .base   (by_ff[F-1][i]),
         .diff   (dy_ff[F-1][i]),
         .ratio  (quo[i]),
         .result (ly[i])
      );
   end

   // pack crossings into slots in visiting order
   always_comb begin
      logic [NC-1:0]        cf;
      logic signed [CB-1:0] cx [NC];
      logic signed [CB-1:0] cy [NC];
      for (int i = 0; i < NV; i++) begin
         cf[2*i]     = zf_ff[DL-1][i];
         cx[2*i]     = bx_ff[DL-1][i];
         cy[2*i]     = by_ff[DL-1][i];
         cf[2*i + 1] = ef_ff[DL-1][i];
         cx[2*i + 1] = lx[i];
         cy[2*i + 1] = ly[i];
      end
      cnt_in = '0;
      for (int i = 0; i < NV; i++) begin
         ox_in[i] = '0;
         oy_in[i] = '0;
      end
      for (int k = 0; k < NC; k++) begin
         if (cf[k] && cnt_in != 2'(NV)) begin
            ox_in[cnt_in] = cx[k];
            oy_in[cnt_in] = cy[k];
            cnt_in        = cnt_in + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cnt_ff <= cnt_in;
         ox_ff  <= ox_in;
         oy_ff  <= oy_in;
         skc_ff <= cnt_ff;
         skx_ff <= ox_ff;
         sky_ff <= oy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         skid_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff      <= {vld_ff[NS-2:0], req_valid};
         skid_vld_ff <= vld_ff[NS-1] && !rsp_ready;
      end else if (rsp_ready) begin
         skid_vld_ff <= 1'b0;
      end
   end

   assign rsp_valid          = skid_vld_ff || vld_ff[NS-1];
   assign rsp_crossing_count = skid_vld_ff ? skc_ff    : cnt_ff;
   assign rsp_point0_x       = skid_vld_ff ? skx_ff[0] : ox_ff[0];
   assign rsp_point0_y       = skid_vld_ff ? sky_ff[0] : oy_ff[0];
   assign rsp_point1_x       = skid_vld_ff ? skx_ff[1] : ox_ff[1];
   assign rsp_point1_y       = skid_vld_ff ? sky_ff[1] : oy_ff[1];
   assign rsp_point2_x       = skid_vld_ff ? skx_ff[2] : ox_ff[2];
   assign rsp_point2_y       = skid_vld_ff ? sky_ff[2] : oy_ff[2];

endmodule

/* sv/tic_divider.sv */
module tic_divider #(
   parameter int COORD_BITS = tic_pkg::TIC_COORD_BITS,
   parameter int FRAC_BITS  = tic_pkg::TIC_FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [COORD_BITS-1:0] num,
   input  logic [COORD_BITS-1:0] den,
   output logic [FRAC_BITS-1:0]  quo
);
   import tic_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int F  = FRAC_BITS;

   logic [CB-1:0] rem_ff [F];
   logic [CB-1:0] den_ff [F];
   logic [F-1:0]  q_ff   [F];

   // one quotient bit per stage, remainder stays below the divisor when the dividend starts below it
   for (genvar k = 0; k < F; k++) begin : g_stage
      logic [CB-1:0] rem_prev;
      logic [CB-1:0] den_prev;
      logic [F-1:0]  q_prev;
      logic [CB:0]   rem2;
      logic [CB:0]   sub;
      logic          qbit;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      assign rem2 = {rem_prev, 1'b0};
      assign sub  = rem2 - {1'b0, den_prev};
      assign qbit = rem2 >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= qbit ? sub[CB-1:0] : rem2[CB-1:0];
            den_ff[k] <= den_prev;
            q_ff[k]   <= {q_prev[F-2:0], qbit};
         end
      end
   end

   assign quo = q_ff[F-1];

endmodule

/* sv/tic_lerp.sv */
module tic_lerp #(
   parameter int COORD_BITS = tic_pkg::TIC_COORD_BITS,
   parameter int FRAC_BITS  = tic_pkg::TIC_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [COORD_BITS-1:0] base,
   input  logic signed [COORD_BITS:0]   diff,
   input  logic        [FRAC_BITS-1:0]  ratio,
   output logic signed [COORD_BITS-1:0] result
);
   import tic_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int PW = CB + F + 2;
   localparam int SW = CB + 2;

   localparam logic signed [PW-1:0] HALF = {{(PW-1){1'b0}}, 1'b1} << (F - 1);
   localparam logic signed [SW-1:0] CMAX = {3'b000, {(CB-1){1'b1}}};
   localparam logic signed [SW-1:0] CMIN = {3'b111, {(CB-1){1'b0}}};

   logic signed [F:0]    rs;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [CB-1:0] base_ff;
   logic signed [PW-1:0] rnd;
   logic signed [PW-1:0] shr;
   logic signed [SW-1:0] off;
   logic signed [SW-1:0] sum;
   logic signed [CB-1:0] result_in;
   logic signed [CB-1:0] result_ff;

   assign rs      = {1'b0, ratio};
   assign prod_in = PW'(diff) * PW'(rs);

   // round half up, then saturate to the coordinate range
   assign rnd = prod_ff + HALF;
   assign shr = rnd >>> F;
   assign off = shr[SW-1:0];
   assign sum = SW'(base_ff) + off;

   always_comb begin
      if (sum > CMAX) begin
         result_in = CMAX[CB-1:0];
      end else if (sum < CMIN) begin
         result_in = CMIN[CB-1:0];
      end else begin
         result_in = sum[CB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         base_ff   <= base;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

/* tb/sv/triangle_isoline_crossings_tb.sv */
module triangle_isoline_crossings_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = tic_pkg::TIC_COORD_BITS;
   localparam int FB = tic_pkg::TIC_FRAC_BITS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 4 * (FB + 4);
   localparam int RANDOM_ITEMS = 1450;
   localparam int LONG_HOLD_CYCLES = 300;

   localparam longint COORD_HI = (longint'(1) <<< (CW - 1)) - 1;
   localparam longint COORD_LO = -COORD_HI - 1;
   localparam longint RATIO_ONE = longint'(1) <<< FB;
   localparam longint HALF_LSB = longint'(1) <<< (FB - 1);

   typedef logic signed [CW-1:0] coord_type;

   localparam coord_type CMAX = coord_type'(COORD_HI);
   localparam coord_type CMIN = coord_type'(COORD_LO);
   localparam coord_type UNIT = coord_type'(RATIO_ONE);

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type value;
   } vertex_type;

   typedef struct packed {
      vertex_type a;
      vertex_type b;
      vertex_type c;
   } triangle_type;

   typedef struct packed {
      tic_pkg::count_type count;
      coord_type p0x;
      coord_type p0y;
      coord_type p1x;
      coord_type p1y;
      coord_type p2x;
      coord_type p2y;
   } crossings_type;

   typedef struct {
      triangle_type  shape;
      bit            typed;
      crossings_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   coord_type          req_vertex_a_x;
   coord_type          req_vertex_a_y;
   coord_type          req_vertex_a_value;
   coord_type          req_vertex_b_x;
   coord_type          req_vertex_b_y;
   coord_type          req_vertex_b_value;
   coord_type          req_vertex_c_x;
   coord_type          req_vertex_c_y;
   coord_type          req_vertex_c_value;
   logic               rsp_valid;
   logic               rsp_ready;
   tic_pkg::count_type rsp_crossing_count;
   coord_type          rsp_point0_x;
   coord_type          rsp_point0_y;
   coord_type          rsp_point1_x;
   coord_type          rsp_point1_y;
   coord_type          rsp_point2_x;
   coord_type          rsp_point2_y;

   crossings_type crossings_q[$];
   stim_row_type  directed_rows[$];
   int            mismatch_count = 0;
   int            word_index = 0;
   int            cycle_count = 0;
   bit            burst_mode = 1'b0;
   bit            long_hold_due = 1'b0;

   triangle_isoline_crossings dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_vertex_a_x     (req_vertex_a_x),
      .req_vertex_a_y     (req_vertex_a_y),
      .req_vertex_a_value (req_vertex_a_value),
      .req_vertex_b_x     (req_vertex_b_x),
      .req_vertex_b_y     (req_vertex_b_y),
      .req_vertex_b_value (req_vertex_b_value),
      .req_vertex_c_x     (req_vertex_c_x),
      .req_vertex_c_y     (req_vertex_c_y),
      .req_vertex_c_value (req_vertex_c_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_crossing_count (rsp_crossing_count),
      .rsp_point0_x       (rsp_point0_x),
      .rsp_point0_y       (rsp_point0_y),
      .rsp_point1_x       (rsp_point1_x),
      .rsp_point1_y       (rsp_point1_y),
      .rsp_point2_x       (rsp_point2_x),
      .rsp_point2_y       (rsp_point2_y)
   );

   always #4 clock = ~clock;

   function automatic vertex_type vtx(coord_type x, coord_type y, coord_type value);
      vertex_type v;
      v.x = x;
      v.y = y;
      v.value = value;
      return v;
   endfunction

   function automatic triangle_type triangle_of(vertex_type a, vertex_type b,
                                                vertex_type c);
      triangle_type t;
      t.a = a;
      t.b = b;
      t.c = c;
      return t;
   endfunction

   function automatic crossings_type crossings_of(int n, coord_type p0x, coord_type p0y,
                                                  coord_type p1x, coord_type p1y,
                                                  coord_type p2x, coord_type p2y);
      crossings_type c;
      c.count = tic_pkg::count_type'(n);
      c.p0x = p0x;
      c.p0y = p0y;
      c.p1x = p1x;
      c.p1y = p1y;
      c.p2x = p2x;
      c.p2y = p2y;
      return c;
   endfunction

   // point on the edge at the given Q1.FB ratio, rounded half up, saturated
   function automatic coord_type interpolate(longint p0, longint p1, longint ratio);
      longint offset;
      longint sum;
      offset = ((p1 - p0) * ratio + HALF_LSB) >>> FB;
      sum = p0 + offset;
      if (sum > COORD_HI) sum = COORD_HI;
      if (sum < COORD_LO) sum = COORD_LO;
      return coord_type'(sum);
   endfunction

   function automatic crossings_type predict_crossings(triangle_type t);
      longint     px [3];
      longint     py [3];
      longint     pv [3];
      coord_type  cx [3];
      coord_type  cy [3];
      int         found;
      int         i;
      int         j;
      longint     num;
      longint     den;
      longint     ratio;
      px[0] = t.a.x;
      py[0] = t.a.y;
      pv[0] = t.a.value;
      px[1] = t.b.x;
      py[1] = t.b.y;
      pv[1] = t.b.value;
      px[2] = t.c.x;
      py[2] = t.c.y;
      pv[2] = t.c.value;
      for (i = 0; i < 3; i++) begin
         cx[i] = '0;
         cy[i] = '0;
      end
      found = 0;
      for (i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         if (pv[i] == 0 && found < 3) begin
            cx[found] = coord_type'(px[i]);
            cy[found] = coord_type'(py[i]);
            found++;
         end
         if (((pv[i] < 0 && pv[j] > 0) || (pv[i] > 0 && pv[j] < 0)) && found < 3) begin
            num = (pv[i] < 0) ? -pv[i] : pv[i];
            den = pv[i] - pv[j];
            if (den < 0) den = -den;
            ratio = (num <<< FB) / den;
            if (ratio > RATIO_ONE) ratio = RATIO_ONE;
            cx[found] = interpolate(px[i], px[j], ratio);
            cy[found] = interpolate(py[i], py[j], ratio);
            found++;
         end
      end
      return crossings_of(found, cx[0], cy[0], cx[1], cy[1], cx[2], cy[2]);
   endfunction

   function automatic coord_type random_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: begin
            case ($urandom_range(0, 3))
               0: return CMAX;
               1: return CMIN;
               2: return coord_type'(1);
               default: return coord_type'(-1);
            endcase
         end
         2: return $urandom_range(0, 1) ? coord_type'($urandom_range(1, 15))
                                        : -coord_type'($urandom_range(1, 15));
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 9))
         0: return CMAX;
         1: return CMIN;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic triangle_type random_triangle();
      vertex_type v [3];
      int         i;
      for (i = 0; i < 3; i++) v[i] = vtx(random_coord(), random_coord(), random_value());
      return triangle_of(v[0], v[1], v[2]);
   endfunction

   // mostly no gap, some short, a few long
   function automatic int pick_idle();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_typed(triangle_type shape, crossings_type want);
      stim_row_type row;
      row.shape = shape;
      row.typed = 1'b1;
      row.want = want;
      directed_rows = {directed_rows, row};
   endtask

   task automatic add_predicted(triangle_type shape);
      stim_row_type row;
      row.shape = shape;
      row.typed = 1'b0;
      row.want = '0;
      directed_rows = {directed_rows, row};
   endtask

   task automatic report_failure(string msg);
      mismatch_count++;
      $display("error: %s", msg);
   endtask

   task automatic send_triangle(triangle_type shape, crossings_type want);
      int gap;
      gap = pick_idle();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_vertex_a_x     <= shape.a.x;
      req_vertex_a_y     <= shape.a.y;
      req_vertex_a_value <= shape.a.value;
      req_vertex_b_x     <= shape.b.x;
      req_vertex_b_y     <= shape.b.y;
      req_vertex_b_value <= shape.b.value;
      req_vertex_c_x     <= shape.c.x;
      req_vertex_c_y     <= shape.c.y;
      req_vertex_c_value <= shape.c.value;
      do @(posedge clock); while (!req_ready);
      crossings_q = {crossings_q, want};
   endtask

   task automatic check_word(crossings_type got);
      crossings_type want;
      longint        got_f [7];
      longint        want_f [7];
      string         names [7];
      int            k;
      if (crossings_q.size() == 0) begin
         report_failure($sformatf("word %0d arrived with nothing expected", word_index));
         return;
      end
      want = crossings_q.pop_front();
      names = '{"crossing_count", "point0_x", "point0_y", "point1_x", "point1_y",
                "point2_x", "point2_y"};
      got_f = '{got.count, got.p0x, got.p0y, got.p1x, got.p1y, got.p2x, got.p2y};
      want_f = '{want.count, want.p0x, want.p0y, want.p1x, want.p1y, want.p2x, want.p2y};
      for (k = 0; k < 7; k++) begin
         if (got_f[k] != want_f[k])
            report_failure($sformatf("word %0d %s got %0d expected %0d",
                                     word_index, names[k], got_f[k], want_f[k]));
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_word(crossings_of(rsp_crossing_count, rsp_point0_x, rsp_point0_y,
                                 rsp_point1_x, rsp_point1_y, rsp_point2_x, rsp_point2_y));
         word_index++;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (long_hold_due) begin
               long_hold_due = 1'b0;
               rsp_ready <= 1'b0;
               stall_left = LONG_HOLD_CYCLES;
            end else if (stall_left > 0) begin
               stall_left--;
            end else if (burst_mode || $urandom_range(0, 3) != 0) begin
               rsp_ready <= 1'b1;
            end else begin
               rsp_ready <= 1'b0;
               stall_left = pick_idle();
            end
         end
      end
   end

   initial begin
      int           n;
      triangle_type shape;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_a_x = '0;
      req_vertex_a_y = '0;
      req_vertex_a_value = '0;
      req_vertex_b_x = '0;
      req_vertex_b_y = '0;
      req_vertex_b_value = '0;
      req_vertex_c_x = '0;
      req_vertex_c_y = '0;
      req_vertex_c_value = '0;

      // all values zero: the vertices themselves; all values of one sign: no crossings
      add_typed(triangle_of(vtx(CMAX, CMIN, 0), vtx(CMIN, CMAX, 0), vtx(0, 0, 0)),
                crossings_of(3, CMAX, CMIN, CMIN, CMAX, 0, 0));
      add_typed(triangle_of(vtx(CMAX, CMAX, CMAX), vtx(CMIN, CMIN, CMAX), vtx(0, 0, CMAX)),
                crossings_of(0, 0, 0, 0, 0, 0, 0));
      add_typed(triangle_of(vtx(CMIN, CMAX, CMIN), vtx(CMAX, CMIN, CMIN), vtx(1, 1, CMIN)),
                crossings_of(0, 0, 0, 0, 0, 0, 0));
      // zero vertex, edges touching it are not sign changes
      add_typed(triangle_of(vtx(100, 200, 0), vtx(CMAX, CMAX, 5), vtx(CMIN, CMIN, 7)),
                crossings_of(1, 100, 200, 0, 0, 0, 0));
      add_typed(triangle_of(vtx(1, 2, 0), vtx(3, 4, 0), vtx(5, 6, -1)),
                crossings_of(2, 1, 2, 3, 4, 0, 0));
      add_typed(triangle_of(vtx(10, 20, -3), vtx(30, 40, -5), vtx(-7, -9, 0)),
                crossings_of(1, -7, -9, 0, 0, 0, 0));
      // midpoint crossings on the edges from a to b and from c to a
      add_typed(triangle_of(vtx(0, 0, -1), vtx(UNIT, UNIT, 1), vtx(UNIT, UNIT, 1)),
                crossings_of(2, UNIT / 2, UNIT / 2, UNIT / 2, UNIT / 2, 0, 0));
      add_predicted(triangle_of(vtx(0, 0, UNIT), vtx(-300, 400, 0), vtx(UNIT, UNIT, -UNIT)));
      add_predicted(triangle_of(vtx(0, 0, 0), vtx(500, -500, 9), vtx(-800, 800, -3)));
      add_predicted(triangle_of(vtx(CMIN, CMIN, CMIN), vtx(CMAX, CMAX, CMAX),
                                vtx(0, 0, CMAX)));
      add_predicted(triangle_of(vtx(CMAX, CMIN, CMAX), vtx(CMIN, CMAX, CMIN),
                                vtx(CMAX, CMAX, 1)));
      add_predicted(triangle_of(vtx(CMIN, CMAX, 1), vtx(CMAX, CMIN, -1), vtx(CMIN, CMIN, 1)));
      add_predicted(triangle_of(vtx(5000, -5000, 1), vtx(-5000, 5000, CMIN),
                                vtx(0, 0, CMIN)));
      add_predicted(triangle_of(vtx(16'sh5555, 16'sh2aaa, -2), vtx(-16'sh5556, -16'sh2aab, 3),
                                vtx(16'sh0f0f, -16'sh0f10, CMAX)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_triangle(directed_rows[r].shape,
                       directed_rows[r].typed ? directed_rows[r].want
                                              : predict_crossings(directed_rows[r].shape));

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            // fill the pipeline behind a long receiver hold-off
            burst_mode = 1'b1;
            long_hold_due = 1'b1;
         end
         if (n == 420) burst_mode = 1'b0;
         if (n == 800) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (crossings_q.size() != 0);
         end
         if (n == 1000) burst_mode = 1'b1;
         if (n == 1150) burst_mode = 1'b0;
         shape = random_triangle();
         send_triangle(shape, predict_crossings(shape));
      end
      req_valid <= 1'b0;

      while (crossings_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
